### rtl/core/sli_pkg.sv
// Shared types, codes and elaboration-time helpers for the sorted insertion list.
// No dependencies; used by every module under rtl/core.

package sli_pkg;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed payload widths
    localparam int KIND_W   = 1;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // OR-reduction tree fan-in per registered level
    localparam int TREE_FANIN = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 1'b0,
        KIND_DELETE = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } t_status;

    // Request and response beats
    typedef struct packed {
        t_kind                     kind;
        logic signed [FIELD_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   count;
    } t_rsp;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_REDUCE,
        ST_APPLY
    } t_state;

    // Per-cycle commands broadcast along the chain
    typedef struct packed {
        logic cmp_en;     // latch compare flags against the key
        logic apply_ins;  // shift right from the insertion point
        logic apply_del;  // shift left from the matching entry
    } t_cell_ctl;

    // Width of level l of the reduction tree (level 0 is the leaf vector)
    function automatic int tree_width(input int n, input int l);
        int w;
        w = n;
        for (int k = 0; k < l; k++) begin
            w = (w + TREE_FANIN - 1) / TREE_FANIN;
        end
        return w;
    endfunction

    // Number of registered levels down to a single bit
    function automatic int tree_levels(input int n);
        int w;
        int lvl;
        w   = n;
        lvl = 0;
        while (w > 1) begin
            w   = (w + TREE_FANIN - 1) / TREE_FANIN;
            lvl = lvl + 1;
        end
        return lvl;
    endfunction

    // Bit offset of the output of level l within the packed node vector
    function automatic int tree_offset(input int n, input int l);
        int off;
        off = 0;
        for (int k = 1; k <= l; k++) begin
            off = off + tree_width(n, k);
        end
        return off;
    endfunction

endpackage

### rtl/core/sorted_list_insert_delete.sv
// Top level of the sorted insertion list: sequencer, entry count and cell chain.
// Depends on sli_pkg, sli_cell and sli_or_tree.

// Keeps up to CAPACITY signed values in ascending order in a chain of cells,
// one entry per cell. Insert places the value after all equal copies; delete
// removes the first equal entry. Every request gives one response beat with
// a status and the count after the request. A request passes the compare
// state, where the cells latch their flags, the reduce state, where the flags
// run through the L = ceil(log8(CAPACITY)) registered levels of the OR tree
// that decides whether a delete found its value, then the apply state, which
// waits for a free response slot, shifts the chain and registers the response.
// A new request beat is taken while the previous response still waits.
// Only the low VALUE_WIDTH bits of value are used (sign-extended when wider);
// the count field carries the low seven bits of the count.

module sorted_list_insert_delete #(
    parameter int CAPACITY    = sli_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = sli_pkg::VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  sli_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output sli_pkg::t_rsp o_rsp
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LEVELS = sli_pkg::tree_levels(CAPACITY);
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    // Control and request registers
    sli_pkg::t_state               r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [LVL_W-1:0]              r_lvl, n_lvl;
    logic                          r_rsp_valid, n_rsp_valid;
    sli_pkg::t_rsp                 r_rsp, n_rsp;
    sli_pkg::t_kind                r_kind;
    logic signed [VALUE_WIDTH-1:0] r_key;

    sli_pkg::t_cell_ctl            w_ctl;
    logic                          w_full;
    logic                          w_found;
    logic                          w_req_acc;
    logic                          w_slot_free;

    logic signed [VALUE_WIDTH-1:0] w_data [CAPACITY];
    logic [CAPACITY-1:0]           w_g;
    logic [CAPACITY-1:0]           w_m;
    logic [CAPACITY-1:0]           w_hit;

    assign w_req_acc   = i_req_valid && o_req_ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_slot_free = !r_rsp_valid || i_rsp_ready;

    // Request latch
    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_kind <= i_req.kind;
            r_key  <= VALUE_WIDTH'($signed(i_req.value));
        end
    end

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                          w_valid;
        logic                          w_left_g;
        logic                          w_left_m;
        logic signed [VALUE_WIDTH-1:0] w_left_data;
        logic signed [VALUE_WIDTH-1:0] w_right_data;

        assign w_valid = (CNT_W'(i) < r_count);

        if (i == 0) begin : g_head
            assign w_left_g    = 1'b0;
            assign w_left_m    = 1'b0;
            assign w_left_data = r_key;
        end else begin : g_body
            assign w_left_g    = w_g[i-1];
            assign w_left_m    = w_m[i-1];
            assign w_left_data = w_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_right_data = w_data[i];
        end else begin : g_next
            assign w_right_data = w_data[i+1];
        end

        sli_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_key        (r_key),
            .i_valid      (w_valid),
            .i_left_g     (w_left_g),
            .i_left_m     (w_left_m),
            .i_left_data  (w_left_data),
            .i_right_data (w_right_data),
            .o_data       (w_data[i]),
            .o_g          (w_g[i]),
            .o_m          (w_m[i]),
            .o_hit        (w_hit[i])
        );
    end

    // Match reduction for delete
    sli_or_tree #(
        .N (CAPACITY)
    ) u_or_tree (
        .i_clk  (i_clk),
        .i_bits (w_hit),
        .o_any  (w_found)
    );

    // Sequencer: next state, cell commands and response
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lvl       = r_lvl;
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        w_ctl       = '0;

        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            sli_pkg::ST_IDLE: begin
                if (w_req_acc) begin
                    n_state = sli_pkg::ST_CMP;
                end
            end
            sli_pkg::ST_CMP: begin
                w_ctl.cmp_en = 1'b1;
                n_lvl        = '0;
                n_state      = sli_pkg::ST_REDUCE;
            end
            sli_pkg::ST_REDUCE: begin
                n_lvl = r_lvl + 1'b1;
                if (r_lvl == LVL_W'(LEVELS - 1)) begin
                    n_state = sli_pkg::ST_APPLY;
                end
            end
            sli_pkg::ST_APPLY: begin
                if (w_slot_free) begin
                    n_state     = sli_pkg::ST_IDLE;
                    n_rsp_valid = 1'b1;
                    if (r_kind == sli_pkg::KIND_INSERT) begin
                        if (w_full) begin
                            n_rsp.status = sli_pkg::STATUS_FULL;
                        end else begin
                            w_ctl.apply_ins = 1'b1;
                            n_count         = r_count + 1'b1;
                            n_rsp.status    = sli_pkg::STATUS_DONE;
                        end
                    end else begin
                        if (w_found) begin
                            w_ctl.apply_del = 1'b1;
                            n_count         = r_count - 1'b1;
                            n_rsp.status    = sli_pkg::STATUS_DONE;
                        end else begin
                            n_rsp.status    = sli_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    n_rsp.count = sli_pkg::COUNT_W'(n_count);
                end
            end
            default: begin
                n_state = sli_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sli_pkg::ST_IDLE;
            r_count     <= '0;
            r_lvl       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_lvl       <= n_lvl;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Response beat payload
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_req_ready = (r_state == sli_pkg::ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

### rtl/core/sli_cell.sv
// One compare-and-shift cell of the sorted chain: holds one entry and its flags.
// Depends on sli_pkg (t_cell_ctl).

module sli_cell #(
    parameter int VALUE_WIDTH = sli_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  sli_pkg::t_cell_ctl            i_ctl,
    input  logic signed [VALUE_WIDTH-1:0] i_key,
    input  logic                          i_valid,
    input  logic                          i_left_g,
    input  logic                          i_left_m,
    input  logic signed [VALUE_WIDTH-1:0] i_left_data,
    input  logic signed [VALUE_WIDTH-1:0] i_right_data,
    output logic signed [VALUE_WIDTH-1:0] o_data,
    output logic                          o_g,
    output logic                          o_m,
    output logic                          o_hit
);

    logic signed [VALUE_WIDTH-1:0] r_data;
    logic                          r_g;   // empty, or entry above key
    logic                          r_m;   // occupied and entry at or above key
    logic                          r_eq;  // occupied and entry equal to key

    // Local compare against the broadcast key
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_g  <= !i_valid || (r_data > i_key);
            r_m  <= i_valid && (r_data >= i_key);
            r_eq <= i_valid && (r_data == i_key);
        end
    end

    // Entry update: shift right on insert, left on delete
    always_ff @(posedge i_clk) begin
        if (i_ctl.apply_ins && r_g) begin
            r_data <= i_left_g ? i_left_data : i_key;
        end else if (i_ctl.apply_del && r_m) begin
            r_data <= i_right_data;
        end
    end

    assign o_data = r_data;
    assign o_g    = r_g;
    assign o_m    = r_m;
    // first entry at or above the key, and equal to it
    assign o_hit  = r_eq && !i_left_m;

endmodule

### rtl/core/sli_or_tree.sv
// Registered OR-reduction tree over the per-cell match flags.
// Depends on sli_pkg (tree sizing helpers).

module sli_or_tree #(
    parameter int N = sli_pkg::CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic [N-1:0] i_bits,
    output logic         o_any
);

    localparam int LEVELS = sli_pkg::tree_levels(N);
    localparam int TOTAL  = sli_pkg::tree_offset(N, LEVELS);
    localparam int FANIN  = sli_pkg::TREE_FANIN;

    logic [TOTAL-1:0] r_node;

    // One register stage per level, up to FANIN inputs per node
    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        localparam int WI      = sli_pkg::tree_width(N, l);
        localparam int WO      = sli_pkg::tree_width(N, l + 1);
        localparam int IN_OFF  = (l == 0) ? 0 : sli_pkg::tree_offset(N, l - 1);
        localparam int OUT_OFF = sli_pkg::tree_offset(N, l);

        logic [WI-1:0] w_in;

        if (l == 0) begin : g_leaf
            assign w_in = i_bits;
        end else begin : g_inner
            assign w_in = r_node[IN_OFF+WI-1:IN_OFF];
        end

        for (genvar j = 0; j < WO; j++) begin : g_node
            localparam int LO = FANIN * j;
            localparam int HI = (LO + FANIN - 1 < WI - 1) ? LO + FANIN - 1 : WI - 1;

            always_ff @(posedge i_clk) begin
                r_node[OUT_OFF+j] <= |w_in[HI:LO];
            end
        end
    end

    assign o_any = r_node[TOTAL-1];

endmodule
